[rtl/gwm_pkg.sv]
// gwm_pkg: request/response payload types, opcodes and glob character codes
// for the glob wildcard matcher. No dependencies.
`default_nettype none

package gwm_pkg;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_NAME   = 2'd2;
   localparam logic [1:0] OP_END    = 2'd3;

   localparam logic [15:0] CH_STAR  = 16'h002A;
   localparam logic [15:0] CH_QMARK = 16'h003F;
   localparam logic [15:0] CH_SEMI  = 16'h003B;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] char_code;
   } req_type;

   typedef struct packed {
      logic matched;
      logic filter_overflow;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/glob_wildcard_matcher.sv]
// glob_wildcard_matcher: top level, filter store and bit-parallel position set.
// Depends on gwm_pkg.
`default_nettype none

// Matches file names against a filter of ';'-separated glob alternatives
// ('*' any run, '?' one character, case-sensitive). Load the filter with
// clear and append requests, then stream the name characters and close with
// an end-of-name request, which alone returns a response: matched and the
// filter overflow flag. One request is taken every cycle while req_stall is
// low; the response of an end-of-name request is valid the cycle after it is
// taken. Every filter position compares against the name character in
// parallel and star runs close through a log-depth prefix network, which sets
// the cycle time. While a response waits under rsp_stall, req_stall is high.
// No clearing pass is needed after reset.
module glob_wildcard_matcher
   import gwm_pkg::*;
#(
   parameter int FILTER_DEPTH = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int ACT_W = FILTER_DEPTH + 1;
   localparam int LEN_W = $clog2(FILTER_DEPTH + 1);
   localparam int IDX_W = $clog2(FILTER_DEPTH);
   localparam int LVL   = $clog2(FILTER_DEPTH + 1);
   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(FILTER_DEPTH);

   logic [15:0]             char_ff [FILTER_DEPTH];
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [FILTER_DEPTH-1:0] len_mask_ff, len_mask_in;
   logic [ACT_W-1:0]        start_ff, start_in;
   logic [ACT_W-1:0]        active_ff, active_in;
   logic                    begin_ff, begin_in;
   logic                    ovf_ff, ovf_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff;

   logic                    accept;
   logic                    append_we;
   logic [FILTER_DEPTH-1:0] star_v, semi_v, step_ok_v;
   logic [ACT_W-1:0]        onehot_l, s_begin, s_full, nxt;
   logic                    hit;

   function automatic logic [ACT_W-1:0] star_close(input logic [ACT_W-1:0] act,
                                                   input logic [ACT_W-1:0] prop);
      logic [ACT_W-1:0] g;
      logic [ACT_W-1:0] pr;
      g  = act;
      pr = prop;
      for (int k = 0; k < LVL; k++) begin
         g  = g | (pr & (g << (1 << k)));
         pr = pr & (pr << (1 << k));
      end
      return g;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      for (int p = 0; p < FILTER_DEPTH; p++) begin
         star_v[p]    = len_mask_ff[p] && (char_ff[p] == CH_STAR);
         semi_v[p]    = len_mask_ff[p] && (char_ff[p] == CH_SEMI);
         step_ok_v[p] = len_mask_ff[p] && (char_ff[p] != CH_STAR)
                        && (char_ff[p] != CH_SEMI)
                        && ((char_ff[p] == CH_QMARK) || (char_ff[p] == req_data.char_code));
      end
   end

   assign nxt = star_close({1'b0, active_ff[FILTER_DEPTH-1:0] & star_v}
                           | {active_ff[FILTER_DEPTH-1:0] & step_ok_v, 1'b0},
                           {star_v, 1'b0});

   assign onehot_l  = ACT_W'(1) << len_ff;
   assign append_we = accept && (req_data.opcode == OP_APPEND) && (len_ff < DEPTH_LEN);
   assign s_begin   = start_ff | ((begin_ff && (req_data.char_code != CH_SEMI))
                                  ? onehot_l : '0);
   assign s_full    = s_begin | (((req_data.char_code == CH_STAR) && |(s_begin & onehot_l))
                                 ? (onehot_l << 1) : '0);

   assign hit = (len_ff != '0)
                && (active_ff[len_ff] || |(active_ff[FILTER_DEPTH-1:0] & semi_v));

   always_comb begin
      len_in       = len_ff;
      len_mask_in  = len_mask_ff;
      start_in     = start_ff;
      active_in    = active_ff;
      begin_in     = begin_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         unique case (req_data.opcode)
            OP_CLEAR: begin
               len_in      = '0;
               len_mask_in = '0;
               start_in    = '0;
               active_in   = '0;
               begin_in    = 1'b1;
               ovf_in      = 1'b0;
            end
            OP_APPEND: begin
               if (append_we) begin
                  len_in      = len_ff + LEN_W'(1);
                  len_mask_in = len_mask_ff | onehot_l[FILTER_DEPTH-1:0];
                  start_in    = s_full;
                  active_in   = s_full;
                  begin_in    = (req_data.char_code == CH_SEMI);
               end else begin
                  ovf_in    = 1'b1;
                  active_in = start_ff;
               end
            end
            OP_NAME: begin
               active_in = nxt;
            end
            OP_END: begin
               active_in    = start_ff;
               rsp_valid_in = 1'b1;
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         len_mask_ff  <= '0;
         start_ff     <= '0;
         active_ff    <= '0;
         begin_ff     <= 1'b1;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         len_mask_ff  <= len_mask_in;
         start_ff     <= start_in;
         active_ff    <= active_in;
         begin_ff     <= begin_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (append_we) begin
         char_ff[len_ff[IDX_W-1:0]] <= req_data.char_code;
      end
      if (accept && (req_data.opcode == OP_END)) begin
         rsp_data_ff.matched         <= hit;
         rsp_data_ff.filter_overflow <= ovf_ff;
      end
   end

`ifndef SYNTH
   a_active_in_range: assert property (@(posedge clock) disable iff (reset)
      (active_ff & ~{len_mask_ff, 1'b1}) == '0)
      else $error("active position beyond filter length");

   a_restart_after_end: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.opcode == OP_END)) |=> (active_ff == start_ff))
      else $error("position set not restarted after end of name");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (len_ff == DEPTH_LEN))
      else $error("overflow flagged with free filter storage");

   a_end_responds: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.opcode == OP_END)) |=> rsp_valid_ff)
      else $error("end of name gave no response");
`endif

endmodule

`default_nettype wire
